// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion lbl failed");

// same check that a condition never holds
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

// ===== rtl/dslt_pkg.sv =====
package dslt_pkg;

  localparam int unsigned SIG_DEPTH = 256;
  localparam int unsigned SIG_AW    = 8;
  localparam logic [31:0] EXP_STEP  = 32'd4034748382;

  typedef enum logic [2:0] {
    MODE_WEIGHT = 3'd0,
    MODE_BIAS   = 3'd1,
    MODE_FWD    = 3'd2,
    MODE_ERR    = 3'd3,
    MODE_UPD    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CFG_RATE   = 2'd0,
    CFG_ICOUNT = 2'd1,
    CFG_NCOUNT = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_WX, MUL_WG, MUL_SD, MUL_VD, MUL_RX, MUL_PG, MUL_RG
  } mul_e;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_BIAS, ACC_CLR, ACC_ADD
  } acc_e;

  typedef enum logic [4:0] {
    C_IDLE, C_DECODE,
    C_F_RD, C_F_MUL, C_F_ACC, C_F_Z, C_F_SIG, C_F_OUT,
    C_E_SIG, C_E_MUL1, C_E_D, C_E_MUL2, C_E_G,
    C_B_RD, C_B_MUL, C_B_ACC, C_B_OUT,
    C_U_RD, C_U_M1, C_U_M2, C_U_W, C_U_B, C_U_BW
  } ctrl_e;

  typedef enum logic [2:0] {
    I_HI, I_LO, I_DIV, I_WR, I_MUL, I_UPD, I_DONE
  } init_e;

  typedef struct packed {
    logic [3:0] n;
    logic [3:0] c;
    logic       item_load;
    logic       rd;
    logic       sig_rd;
    logic       sig_from_pre;
    mul_e       mul;
    acc_e       acc;
    logic       z_ld;
    logic       d_ld;
    logic       w_we;
    logic       w_upd;
    logic       b_we;
    logic       b_upd;
    logic       x_we;
    logic       p_we;
    logic       g_we;
    logic       out_ld;
    logic       out_kind;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    mode_e      mode;
    logic       last;
    logic [3:0] row;
    logic [3:0] col;
    logic       row_ok;
    logic       col_ok;
    logic [3:0] ni_last;
    logic [3:0] nn_last;
    logic       out_full;
  } status_t;

  typedef struct packed {
    logic              we;
    logic [SIG_AW-1:0] addr;
    logic [15:0]       data;
  } sig_wr_t;

  function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
    if (v > 51'sd32767) return 16'sh7fff;
    else if (v < -51'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

endpackage

// ===== rtl/dense_sigmoid_layer_trainer_unit.sv =====
// channel      dir  tdata (low bit up)                   tuser   tlast
// s_axis       in   row[3:0] col[7:4] value[23:8]        mode    last
// m_axis       out  index[3:0] value_res[19:4]
//                   pre_activation[35:20] zero[39:36]    kind    last_res
// cfg          in   cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// writes pass through decode; an error element adds sig, mul, d, mul and grad steps
// forward pass: one shared multiplier, each mac a read, multiply and accumulate step
// weighted error: read, mul, acc per term; update: read, two muls, write, then bias
// after reset the sigmoid table is built before any beat is taken
// a stalled result holds the output register; the next pass result waits on it

module dense_sigmoid_layer_trainer_unit #(
  parameter int unsigned MAX_INPUTS  = 16,
  parameter int unsigned MAX_NEURONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row, col, value
  input  logic [2:0]  s_axis_tuser,   // mode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // index, value_res, pre_activation, zero pad
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast
);

  localparam int unsigned NI = MAX_INPUTS < 16 ? MAX_INPUTS : 16;
  localparam int unsigned NN = MAX_NEURONS < 16 ? MAX_NEURONS : 16;

  dslt_pkg::cmd_t    cmd;
  dslt_pkg::status_t st;
  dslt_pkg::sig_wr_t sig_wr;
  logic              init_done;
  logic [3:0]        index;
  logic signed [15:0] value_res, pre_act;

  dslt_sig_init u_init (
    .clk_i, .rst_ni, .wr_o(sig_wr), .done_o(init_done)
  );

  dslt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .init_done_i(init_done), .st_i(st), .cmd_o(cmd)
  );

  dslt_dpath #(.NUM_IN(NI), .NUM_NEU(NN)) u_dpath (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .mode_i(s_axis_tuser), .row_i(s_axis_tdata[3:0]), .col_i(s_axis_tdata[7:4]),
    .value_i(s_axis_tdata[23:8]), .last_i(s_axis_tlast),
    .cmd_i(cmd), .sig_wr_i(sig_wr), .st_o(st),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .kind_o(m_axis_tuser), .index_o(index), .value_res_o(value_res),
    .pre_activation_o(pre_act), .last_res_o(m_axis_tlast)
  );

  assign m_axis_tdata = {4'h0, pre_act, value_res, index};

endmodule

// ===== rtl/dslt_ram.sv =====
module dslt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dslt_sig_init.sv =====
module dslt_sig_init (
  input  logic             clk_i,
  input  logic             rst_ni,
  output dslt_pkg::sig_wr_t wr_o,
  output logic             done_o
);

  dslt_pkg::init_e state_q, state_d;
  logic [7:0]  k_q, k_d;
  logic [32:0] e_q, e_d;
  logic [34:0] rem_q, rem_d;
  logic [12:0] num_q, num_d;
  logic [12:0] quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        lo_q, lo_d;
  logic [64:0] prod_q, prod_d;

  logic [33:0] den;
  logic [45:0] num_hi, num_lo, num_sel;
  logic [34:0] trial;
  logic        fits;

  assign den     = 34'h1_0000_0000 + 34'(e_q);
  assign num_hi  = (46'd1 << 44) + 46'(den >> 1);
  assign num_lo  = (46'(e_q) << 12) + 46'(den >> 1);
  assign num_sel = (state_q == dslt_pkg::I_LO) ? num_lo : num_hi;
  // restoring divider, one quotient bit per cycle
  assign trial   = {rem_q[33:0], num_q[12]};
  assign fits    = trial >= 35'(den);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dslt_pkg::I_HI;
      k_q     <= '0;
      e_q     <= 33'h1_0000_0000;
      cnt_q   <= '0;
      lo_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      e_q     <= e_d;
      cnt_q   <= cnt_d;
      lo_q    <= lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    prod_q <= prod_d;
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    e_d     = e_q;
    rem_d   = rem_q;
    num_d   = num_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    lo_d    = lo_q;
    prod_d  = prod_q;
    wr_o    = '0;
    case (state_q)
      dslt_pkg::I_HI, dslt_pkg::I_LO: begin
        rem_d   = 35'(num_sel >> 13);
        num_d   = num_sel[12:0];
        quo_d   = '0;
        cnt_d   = 4'd13;
        lo_d    = (state_q == dslt_pkg::I_LO);
        state_d = dslt_pkg::I_DIV;
      end
      dslt_pkg::I_DIV: begin
        rem_d = fits ? trial - 35'(den) : trial;
        num_d = {num_q[11:0], 1'b0};
        quo_d = {quo_q[11:0], fits};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) state_d = dslt_pkg::I_WR;
      end
      dslt_pkg::I_WR: begin
        wr_o.we   = lo_q ? (k_q != 8'd0) : (k_q != 8'd128);
        wr_o.addr = lo_q ? 8'd128 - k_q : 8'd128 + k_q;
        wr_o.data = {3'b000, quo_q};
        state_d   = lo_q ? dslt_pkg::I_MUL : dslt_pkg::I_LO;
      end
      dslt_pkg::I_MUL: begin
        prod_d  = 65'(e_q) * 65'(dslt_pkg::EXP_STEP);
        state_d = (k_q == 8'd128) ? dslt_pkg::I_DONE : dslt_pkg::I_UPD;
      end
      dslt_pkg::I_UPD: begin
        e_d     = prod_q[64:32];
        k_d     = k_q + 8'd1;
        state_d = dslt_pkg::I_HI;
      end
      dslt_pkg::I_DONE: ;
      default: state_d = dslt_pkg::I_HI;
    endcase
  end

  assign done_o = (state_q == dslt_pkg::I_DONE);

endmodule

// ===== rtl/dslt_ctrl.sv =====
module dslt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               init_done_i,
  input  dslt_pkg::status_t  st_i,
  output dslt_pkg::cmd_t     cmd_o
);

  dslt_pkg::ctrl_e state_q, state_d;
  logic [3:0] n_q, n_d, c_q, c_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dslt_pkg::C_IDLE;
      n_q     <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      c_q     <= c_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    c_d        = c_q;
    cmd_o      = '0;
    cmd_o.n    = n_q;
    cmd_o.c    = c_q;
    in_ready_o = 1'b0;
    case (state_q)
      dslt_pkg::C_IDLE: begin
        in_ready_o = init_done_i;
        if (in_valid_i && init_done_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = dslt_pkg::C_DECODE;
        end
      end
      dslt_pkg::C_DECODE: begin
        cmd_o.n = st_i.row;
        cmd_o.c = st_i.col;
        n_d     = '0;
        c_d     = '0;
        state_d = dslt_pkg::C_IDLE;
        case (st_i.mode)
          dslt_pkg::MODE_WEIGHT: cmd_o.w_we = st_i.row_ok && st_i.col_ok;
          dslt_pkg::MODE_BIAS:   cmd_o.b_we = st_i.row_ok;
          dslt_pkg::MODE_FWD: begin
            cmd_o.x_we = st_i.col_ok;
            if (st_i.last) state_d = dslt_pkg::C_F_RD;
          end
          dslt_pkg::MODE_ERR: begin
            if (st_i.row_ok) begin
              cmd_o.rd = 1'b1;
              n_d      = st_i.row;
              state_d  = dslt_pkg::C_E_SIG;
            end else if (st_i.last) begin
              state_d = dslt_pkg::C_B_RD;
            end
          end
          dslt_pkg::MODE_UPD: state_d = dslt_pkg::C_U_RD;
          default: state_d = dslt_pkg::C_IDLE;
        endcase
      end
      // forward pass: each mac is a read, multiply and accumulate state
      dslt_pkg::C_F_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = dslt_pkg::C_F_MUL;
      end
      dslt_pkg::C_F_MUL: begin
        cmd_o.mul = dslt_pkg::MUL_WX;
        if (c_q == 4'd0) cmd_o.acc = dslt_pkg::ACC_BIAS;
        state_d = dslt_pkg::C_F_ACC;
      end
      dslt_pkg::C_F_ACC: begin
        cmd_o.acc = dslt_pkg::ACC_ADD;
        if (c_q == st_i.ni_last) begin
          c_d     = '0;
          state_d = dslt_pkg::C_F_Z;
        end else begin
          c_d     = c_q + 4'd1;
          state_d = dslt_pkg::C_F_RD;
        end
      end
      dslt_pkg::C_F_Z: begin
        cmd_o.z_ld = 1'b1;
        state_d    = dslt_pkg::C_F_SIG;
      end
      dslt_pkg::C_F_SIG: begin
        cmd_o.sig_rd = 1'b1;
        cmd_o.p_we   = 1'b1;
        state_d      = dslt_pkg::C_F_OUT;
      end
      dslt_pkg::C_F_OUT: begin
        if (!st_i.out_full) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_last = (n_q == st_i.nn_last);
          if (n_q == st_i.nn_last) begin
            state_d = dslt_pkg::C_IDLE;
          end else begin
            n_d     = n_q + 4'd1;
            state_d = dslt_pkg::C_F_RD;
          end
        end
      end
      // error element: gradient of one neuron
      dslt_pkg::C_E_SIG: begin
        cmd_o.sig_rd       = 1'b1;
        cmd_o.sig_from_pre = 1'b1;
        state_d            = dslt_pkg::C_E_MUL1;
      end
      dslt_pkg::C_E_MUL1: begin
        cmd_o.mul = dslt_pkg::MUL_SD;
        state_d   = dslt_pkg::C_E_D;
      end
      dslt_pkg::C_E_D: begin
        cmd_o.d_ld = 1'b1;
        state_d    = dslt_pkg::C_E_MUL2;
      end
      dslt_pkg::C_E_MUL2: begin
        cmd_o.mul = dslt_pkg::MUL_VD;
        state_d   = dslt_pkg::C_E_G;
      end
      dslt_pkg::C_E_G: begin
        cmd_o.g_we = 1'b1;
        n_d        = '0;
        c_d        = '0;
        state_d    = st_i.last ? dslt_pkg::C_B_RD : dslt_pkg::C_IDLE;
      end
      // weighted error per input, summed over neurons
      dslt_pkg::C_B_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = dslt_pkg::C_B_MUL;
      end
      dslt_pkg::C_B_MUL: begin
        cmd_o.mul = dslt_pkg::MUL_WG;
        if (n_q == 4'd0) cmd_o.acc = dslt_pkg::ACC_CLR;
        state_d = dslt_pkg::C_B_ACC;
      end
      dslt_pkg::C_B_ACC: begin
        cmd_o.acc = dslt_pkg::ACC_ADD;
        if (n_q == st_i.nn_last) begin
          state_d = dslt_pkg::C_B_OUT;
        end else begin
          n_d     = n_q + 4'd1;
          state_d = dslt_pkg::C_B_RD;
        end
      end
      dslt_pkg::C_B_OUT: begin
        if (!st_i.out_full) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_kind = 1'b1;
          cmd_o.out_last = (c_q == st_i.ni_last);
          n_d            = '0;
          if (c_q == st_i.ni_last) begin
            state_d = dslt_pkg::C_IDLE;
          end else begin
            c_d     = c_q + 4'd1;
            state_d = dslt_pkg::C_B_RD;
          end
        end
      end
      // sgd update, weights of a row then its bias
      dslt_pkg::C_U_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = dslt_pkg::C_U_M1;
      end
      dslt_pkg::C_U_M1: begin
        cmd_o.mul = dslt_pkg::MUL_RX;
        state_d   = dslt_pkg::C_U_M2;
      end
      dslt_pkg::C_U_M2: begin
        cmd_o.mul = dslt_pkg::MUL_PG;
        state_d   = dslt_pkg::C_U_W;
      end
      dslt_pkg::C_U_W: begin
        cmd_o.w_we  = 1'b1;
        cmd_o.w_upd = 1'b1;
        if (c_q == st_i.ni_last) begin
          state_d = dslt_pkg::C_U_B;
        end else begin
          c_d     = c_q + 4'd1;
          state_d = dslt_pkg::C_U_RD;
        end
      end
      dslt_pkg::C_U_B: begin
        cmd_o.mul = dslt_pkg::MUL_RG;
        state_d   = dslt_pkg::C_U_BW;
      end
      dslt_pkg::C_U_BW: begin
        cmd_o.b_we  = 1'b1;
        cmd_o.b_upd = 1'b1;
        c_d         = '0;
        if (n_q == st_i.nn_last) begin
          state_d = dslt_pkg::C_IDLE;
        end else begin
          n_d     = n_q + 4'd1;
          state_d = dslt_pkg::C_U_RD;
        end
      end
      default: state_d = dslt_pkg::C_IDLE;
    endcase
  end

endmodule

// ===== rtl/dslt_dpath.sv =====
module dslt_dpath #(
  parameter int unsigned NUM_IN  = 16,
  parameter int unsigned NUM_NEU = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic [2:0]         mode_i,
  input  logic [3:0]         row_i,
  input  logic [3:0]         col_i,
  input  logic signed [15:0] value_i,
  input  logic               last_i,
  input  dslt_pkg::cmd_t     cmd_i,
  input  dslt_pkg::sig_wr_t  sig_wr_i,
  output dslt_pkg::status_t  st_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [3:0]         index_o,
  output logic signed [15:0] value_res_o,
  output logic signed [15:0] pre_activation_o,
  output logic               last_res_o
);

  localparam int unsigned CW  = NUM_IN > 1 ? $clog2(NUM_IN) : 1;
  localparam int unsigned RW  = NUM_NEU > 1 ? $clog2(NUM_NEU) : 1;
  localparam int unsigned WD  = NUM_IN * NUM_NEU;
  localparam int unsigned WAW = WD > 1 ? $clog2(WD) : 1;

  // configuration
  logic [15:0] rate_q;
  logic [4:0]  icnt_q, ncnt_q;
  logic [4:0]  ni, nn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 16'd655;
      icnt_q <= 5'd16;
      ncnt_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (dslt_pkg::cfg_e'(cfg_idx_i))
        dslt_pkg::CFG_RATE:   rate_q <= cfg_wdata_i;
        dslt_pkg::CFG_ICOUNT: icnt_q <= cfg_wdata_i[4:0];
        dslt_pkg::CFG_NCOUNT: ncnt_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  assign ni = (icnt_q == 5'd0) ? 5'd1 : ((icnt_q > 5'(NUM_IN)) ? 5'(NUM_IN) : icnt_q);
  assign nn = (ncnt_q == 5'd0) ? 5'd1 : ((ncnt_q > 5'(NUM_NEU)) ? 5'(NUM_NEU) : ncnt_q);

  // latched item
  logic [2:0]         mode_q;
  logic [3:0]         row_q, col_q;
  logic signed [15:0] val_q;
  logic               last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      mode_q <= mode_i;
      row_q  <= row_i;
      col_q  <= col_i;
      val_q  <= value_i;
      last_q <= last_i;
    end
  end

  // stores
  logic [RW-1:0]      n_idx;
  logic [CW-1:0]      c_idx;
  logic [WAW-1:0]     w_addr;
  logic signed [15:0] w_rd, b_rd, x_rd, p_rd, g_rd, w_wd, b_wd;
  logic [15:0]        w_rd_u, b_rd_u, x_rd_u, p_rd_u, g_rd_u, s_rd;
  logic signed [15:0] z_q, pre_eff, g_eff, g_new;
  logic [NUM_NEU-1:0] pre_vld_q, grad_vld_q;
  logic               pre_v_q, grad_v_q;
  logic [7:0]         sig_addr;

  assign n_idx  = cmd_i.n[RW-1:0];
  assign c_idx  = cmd_i.c[CW-1:0];
  assign w_addr = WAW'(n_idx) * WAW'(NUM_IN) + WAW'(c_idx);

  assign w_rd = w_rd_u;
  assign b_rd = b_rd_u;
  assign x_rd = x_rd_u;
  assign p_rd = p_rd_u;
  assign g_rd = g_rd_u;

  dslt_ram #(.WIDTH(16), .DEPTH(WD)) u_w_ram (
    .clk_i, .we_i(cmd_i.w_we), .waddr_i(w_addr), .wdata_i(w_wd),
    .re_i(cmd_i.rd), .raddr_i(w_addr), .rdata_o(w_rd_u)
  );
  dslt_ram #(.WIDTH(16), .DEPTH(NUM_NEU)) u_b_ram (
    .clk_i, .we_i(cmd_i.b_we), .waddr_i(n_idx), .wdata_i(b_wd),
    .re_i(cmd_i.rd), .raddr_i(n_idx), .rdata_o(b_rd_u)
  );
  dslt_ram #(.WIDTH(16), .DEPTH(NUM_IN)) u_x_ram (
    .clk_i, .we_i(cmd_i.x_we), .waddr_i(c_idx), .wdata_i(val_q),
    .re_i(cmd_i.rd), .raddr_i(c_idx), .rdata_o(x_rd_u)
  );
  dslt_ram #(.WIDTH(16), .DEPTH(NUM_NEU)) u_p_ram (
    .clk_i, .we_i(cmd_i.p_we), .waddr_i(n_idx), .wdata_i(z_q),
    .re_i(cmd_i.rd), .raddr_i(n_idx), .rdata_o(p_rd_u)
  );
  dslt_ram #(.WIDTH(16), .DEPTH(NUM_NEU)) u_g_ram (
    .clk_i, .we_i(cmd_i.g_we), .waddr_i(n_idx), .wdata_i(g_new),
    .re_i(cmd_i.rd), .raddr_i(n_idx), .rdata_o(g_rd_u)
  );
  dslt_ram #(.WIDTH(16), .DEPTH(dslt_pkg::SIG_DEPTH)) u_sig_ram (
    .clk_i, .we_i(sig_wr_i.we), .waddr_i(sig_wr_i.addr), .wdata_i(sig_wr_i.data),
    .re_i(cmd_i.sig_rd), .raddr_i(sig_addr), .rdata_o(s_rd)
  );

  // preactivation and gradient read as zero until written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q  <= '0;
      grad_vld_q <= '0;
      pre_v_q    <= 1'b0;
      grad_v_q   <= 1'b0;
    end else begin
      if (cmd_i.p_we) pre_vld_q[n_idx] <= 1'b1;
      if (cmd_i.g_we) grad_vld_q[n_idx] <= 1'b1;
      if (cmd_i.rd) begin
        pre_v_q  <= pre_vld_q[n_idx];
        grad_v_q <= grad_vld_q[n_idx];
      end
    end
  end

  assign pre_eff  = pre_v_q ? p_rd : 16'sd0;
  assign g_eff    = grad_v_q ? g_rd : 16'sd0;
  assign sig_addr = cmd_i.sig_from_pre ? {~pre_eff[15], pre_eff[14:8]}
                                       : {~z_q[15], z_q[14:8]};

  // shared multiplier
  logic signed [33:0] ma;
  logic signed [16:0] mb, s_s;
  logic signed [50:0] prod_q, rnd12, acc_ext;
  logic signed [39:0] acc_q;
  logic [12:0]        d_q;

  assign s_s = $signed({1'b0, s_rd});

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.mul)
      dslt_pkg::MUL_WX: begin ma = 34'(w_rd);  mb = 17'(x_rd); end
      dslt_pkg::MUL_WG: begin ma = 34'(w_rd);  mb = 17'(g_eff); end
      dslt_pkg::MUL_SD: begin ma = 34'(s_s);   mb = 17'sd4096 - s_s; end
      dslt_pkg::MUL_VD: begin ma = 34'(val_q); mb = $signed({4'b0000, d_q}); end
      dslt_pkg::MUL_RX: begin ma = 34'(x_rd);  mb = $signed({1'b0, rate_q}); end
      dslt_pkg::MUL_PG: begin ma = $signed(prod_q[33:0]); mb = 17'(g_eff); end
      dslt_pkg::MUL_RG: begin ma = 34'(g_eff); mb = $signed({1'b0, rate_q}); end
      default: ;
    endcase
  end

  assign rnd12   = (prod_q + 51'sd2048) >>> 12;
  assign acc_ext = (51'(acc_q) + 51'sd2048) >>> 12;
  assign g_new   = dslt_pkg::sat16(rnd12);
  assign w_wd    = cmd_i.w_upd
                 ? dslt_pkg::sat16(51'(w_rd) - ((prod_q + 51'sd134217728) >>> 28))
                 : val_q;
  assign b_wd    = cmd_i.b_upd
                 ? dslt_pkg::sat16(51'(b_rd) - ((prod_q + 51'sd32768) >>> 16))
                 : val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul != dslt_pkg::MUL_NONE) prod_q <= ma * mb;
    case (cmd_i.acc)
      dslt_pkg::ACC_BIAS: acc_q <= $signed({{12{b_rd[15]}}, b_rd, 12'h000});
      dslt_pkg::ACC_CLR:  acc_q <= '0;
      dslt_pkg::ACC_ADD:  acc_q <= acc_q + 40'(prod_q);
      default: ;
    endcase
    if (cmd_i.z_ld) z_q <= dslt_pkg::sat16(acc_ext);
    if (cmd_i.d_ld) d_q <= rnd12[12:0];
  end

  // output register
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      kind_o           <= cmd_i.out_kind;
      index_o          <= cmd_i.out_kind ? cmd_i.c : cmd_i.n;
      value_res_o      <= cmd_i.out_kind ? dslt_pkg::sat16(acc_ext) : s_rd;
      pre_activation_o <= cmd_i.out_kind ? 16'sd0 : z_q;
      last_res_o       <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_vld_q;

  assign st_o.mode     = dslt_pkg::mode_e'(mode_q);
  assign st_o.last     = last_q;
  assign st_o.row      = row_q;
  assign st_o.col      = col_q;
  assign st_o.row_ok   = {1'b0, row_q} < 5'(NUM_NEU);
  assign st_o.col_ok   = {1'b0, col_q} < 5'(NUM_IN);
  assign st_o.ni_last  = 4'(ni - 5'd1);
  assign st_o.nn_last  = 4'(nn - 5'd1);
  assign st_o.out_full = out_vld_q;

endmodule

// ===== rtl/dslt_checker.sv =====
`include "assert_macros.svh"

module dslt_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result beat holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  // weighted error beats carry no preactivation
  `ASSERT_NEVER(a_err_pre_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser && m_axis_tdata[35:20] != 16'h0000)
  // activations stay within [0, 1]
  `ASSERT_NEVER(a_sig_range, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser && m_axis_tdata[19:4] > 16'd4096)
  // table build keeps the input closed right after reset
  `ASSERT_CLK(a_init_closed, clk_i, rst_ni, !$past(rst_ni) |-> !s_axis_tready)

endmodule

bind dense_sigmoid_layer_trainer_unit dslt_sva u_dslt_sva (.*);

// ===== test/dslt_checker.sv =====
module dslt_checker
  import dslt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row, col, value
  input  logic [2:0]  s_axis_tuser,   // mode
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // index, value_res, pre_activation, zero pad
  input  logic        m_axis_tuser,   // kind
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    bit        kind;
    bit [3:0]  idx;
    bit [15:0] act;
    bit [15:0] pre;
    bit        fin;
  } layer_out_t;

  layer_out_t         out_q[$];
  logic signed [15:0] weight_m[16][16];
  logic signed [15:0] bias_m[16];
  logic signed [15:0] input_m[16];
  logic signed [15:0] preact_m[16];
  logic signed [15:0] grad_m[16];
  longint             sig_lut[256];
  bit [15:0]          rate;
  bit [4:0]           in_cnt;
  bit [4:0]           nrn_cnt;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int eff_count(bit [4:0] v);
    if (v == 0) return 1;
    return (v > 16) ? 16 : v;
  endfunction

  function automatic longint sig_of(logic signed [15:0] z);
    int zi;
    zi = z;
    return sig_lut[(zi + 32768) >> 8];
  endfunction

  initial begin
    longint unsigned e, den;
    e = 64'd1 << 32;
    for (int k = 0; k <= 128; k++) begin
      den = (64'd1 << 32) + e;
      if (k < 128) sig_lut[128 + k] = ((64'd1 << 44) + den / 2) / den;
      if (k > 0) sig_lut[128 - k] = ((e << 12) + den / 2) / den;
      e = (e * 64'd4034748382) >> 32;
    end
  end

  task automatic layer_step(logic [2:0] mode, bit [3:0] row, bit [3:0] col,
                            logic signed [15:0] v, bit fin);
    int     ni, nn;
    longint acc, s, d, g;
    ni = eff_count(in_cnt);
    nn = eff_count(nrn_cnt);
    case (mode)
      MODE_WEIGHT: weight_m[row][col] = v;
      MODE_BIAS:   bias_m[row] = v;
      MODE_FWD: begin
        input_m[col] = v;
        if (fin) begin
          for (int n = 0; n < nn; n++) begin
            acc = longint'(bias_m[n]) * 4096;
            for (int c = 0; c < ni; c++) acc += longint'(weight_m[n][c]) * input_m[c];
            preact_m[n] = clip16(rnd_shift(acc, 12));
            out_q.push_back('{1'b0, n[3:0], 16'(sig_of(preact_m[n])), preact_m[n],
                              n + 1 == nn});
          end
        end
      end
      MODE_ERR: begin
        s = sig_of(preact_m[row]);
        d = rnd_shift(s * (4096 - s), 12);
        grad_m[row] = clip16(rnd_shift(longint'(v) * d, 12));
        if (fin) begin
          for (int c = 0; c < ni; c++) begin
            acc = 0;
            for (int n = 0; n < nn; n++) acc += longint'(weight_m[n][c]) * grad_m[n];
            out_q.push_back('{1'b1, c[3:0], clip16(rnd_shift(acc, 12)), 16'd0,
                              c + 1 == ni});
          end
        end
      end
      MODE_UPD: begin
        for (int n = 0; n < nn; n++) begin
          g = grad_m[n];
          for (int c = 0; c < ni; c++)
            weight_m[n][c] = clip16(longint'(weight_m[n][c])
                                    - rnd_shift(longint'(rate) * input_m[c] * g, 28));
          bias_m[n] = clip16(longint'(bias_m[n]) - rnd_shift(longint'(rate) * g, 16));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    layer_out_t want;
    if (!rst_ni) begin
      rate = 655;
      in_cnt = 16;
      nrn_cnt = 16;
      for (int i = 0; i < 16; i++) begin
        preact_m[i] = '0;
        grad_m[i] = '0;
      end
      out_q.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (out_q.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = out_q.pop_front();
          if (m_axis_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[3:0] !== want.idx) begin
            $error("index: expected %0d, got %0d", want.idx, m_axis_tdata[3:0]);
            fail_count++;
          end
          if (m_axis_tdata[19:4] !== want.act) begin
            $error("value_res: expected %h, got %h", want.act, m_axis_tdata[19:4]);
            fail_count++;
          end
          if (m_axis_tdata[35:20] !== want.pre) begin
            $error("pre_activation: expected %h, got %h", want.pre, m_axis_tdata[35:20]);
            fail_count++;
          end
          if (m_axis_tlast !== want.fin) begin
            $error("last_res: expected %0d, got %0d", want.fin, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RATE:   rate = cfg_wdata_i;
          CFG_ICOUNT: in_cnt = cfg_wdata_i[4:0];
          CFG_NCOUNT: nrn_cnt = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        layer_step(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[7:4],
                   s_axis_tdata[23:8], s_axis_tlast);
      pending = out_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
module tb;
  import dslt_pkg::*;

  localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] MODE_TOP          = 3'd7;
  localparam int         DRAIN_CYCLES      = 1200;
  localparam int         WATCHDOG_LIMIT    = 30000;
  localparam int         RANDOM_ITEMS      = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // row, col, value
  logic [2:0]  s_axis_tuser = '0;   // mode
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // index, value_res, pre_activation, zero pad
  logic        m_axis_tuser;        // kind
  logic        m_axis_tlast;

  int fail_count, pending;
  bit quiet = 0;
  bit hold_req = 0;
  int in_use = 16;
  int random_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dense_sigmoid_layer_trainer_unit dut (.*);

  dslt_checker chk (.*);

  // receiver: short random stalls plus one long hold-off
  always @(posedge clk_i) begin
    static int stall_left = 0;
    static bit hold_seen = 0;
    if (stall_left == 0) begin
      if (hold_req && !hold_seen) begin
        hold_seen = 1;
        stall_left = 300;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    static int idle_cycles = 0;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8191)) - 16'd4096;
      3: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(logic [2:0] mode, logic [3:0] row, logic [3:0] col,
                      logic [15:0] v, logic fin);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {v, col, row};
    s_axis_tlast <= fin;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // let results drain and any update pass finish before touching registers
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_e idx, logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ICOUNT) in_use = (v[4:0] == 0) ? 1 : (v[4:0] > 16) ? 16 : v[4:0];
  endtask

  task automatic forward_vector();
    int first;
    first = $urandom_range(0, 15);
    for (int i = 0; i < in_use; i++) begin
      if ($urandom_range(0, 7) == 0)
        send(MODE_WEIGHT, 4'($urandom), 4'($urandom), pick_value(), 1'($urandom));
      send(MODE_FWD, 4'($urandom), 4'(first + i), pick_value(), i == in_use - 1);
    end
  endtask

  task automatic error_vector();
    int k;
    k = $urandom_range(1, 6);
    for (int i = 0; i < k; i++)
      send(MODE_ERR, 4'($urandom), 4'($urandom), pick_value(), i == k - 1);
  endtask

  task automatic random_phase(int items);
    int start;
    start = random_sent;
    while (random_sent - start < items && random_sent < RANDOM_ITEMS) begin
      if (random_sent > RANDOM_ITEMS - 70) quiet = 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          forward_vector();
          error_vector();
          if ($urandom_range(0, 1)) send(MODE_UPD, 4'($urandom), 4'($urandom),
                                         16'($urandom), 1'($urandom));
          random_sent += in_use + 4;
        end
        6, 7: begin
          send($urandom_range(0, 1) ? MODE_WEIGHT : MODE_BIAS, 4'($urandom),
               4'($urandom), pick_value(), 1'($urandom));
          random_sent++;
        end
        8: begin
          // noise: unused modes and lone elements without a last mark
          case ($urandom_range(0, 2))
            0: send(3'($urandom_range(MODE_FIRST_UNUSED, MODE_TOP)), 4'($urandom),
                    4'($urandom), 16'($urandom), 1'($urandom));
            1: send(MODE_FWD, 4'($urandom), 4'($urandom), pick_value(), 1'b0);
            default: send(MODE_ERR, 4'($urandom), 4'($urandom), pick_value(), 1'b0);
          endcase
        end
        default: begin
          send($urandom_range(0, 1) ? MODE_FWD : MODE_ERR, 4'($urandom),
               4'($urandom), pick_value(), 1'b1);
          random_sent++;
        end
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    cfg_write(CFG_RATE, 16'd65535);
    cfg_write(CFG_ICOUNT, 16'd16);
    cfg_write(CFG_NCOUNT, 16'd16);

    // every weight and bias gets written before anything reads them
    for (int r = 0; r < 16; r++) begin
      for (int c = 0; c < 16; c++) send(MODE_WEIGHT, 4'(r), 4'(c), pick_value(), 1'b0);
      send(MODE_BIAS, 4'(r), 4'($urandom), pick_value(), 1'b0);
    end
    send(MODE_WEIGHT, 4'd15, 4'd15, 16'h7fff, 1'b1);
    send(MODE_BIAS, 4'd0, 4'd0, 16'h8000, 1'b1);
    send(MODE_BIAS, 4'd15, 4'd0, 16'h7fff, 1'b0);

    // full-size forward pass with extreme inputs
    for (int c = 0; c < 16; c++)
      send(MODE_FWD, 4'($urandom), 4'(c),
           c == 0 ? 16'h8000 : c == 1 ? 16'h7fff : c == 2 ? 16'h0000 : pick_value(),
           c == 15);
    send(MODE_ERR, 4'd0, 4'd0, 16'h8000, 1'b0);
    send(MODE_ERR, 4'd1, 4'd15, 16'h7fff, 1'b0);
    send(MODE_ERR, 4'd15, 4'd0, 16'h0fff, 1'b1);
    send(MODE_UPD, 4'd0, 4'd0, 16'hffff, 1'b1);
    for (logic [3:0] m = MODE_FIRST_UNUSED; m <= MODE_TOP; m++)
      send(m[2:0], 4'hf, 4'hf, 16'hffff, 1'b1);
    send(MODE_FWD, 4'd0, 4'd3, 16'h1000, 1'b1);
    send(MODE_ERR, 4'd7, 4'd0, 16'h1000, 1'b1);

    // counts at the extremes and out of range, rate at both ends
    drain();
    cfg_write(CFG_ICOUNT, 16'd1);
    cfg_write(CFG_NCOUNT, 16'd1);
    cfg_write(CFG_RATE, 16'd0);
    random_phase(30);

    drain();
    cfg_write(CFG_ICOUNT, 16'd0);
    cfg_write(CFG_NCOUNT, 16'd31);
    cfg_write(CFG_RATE, 16'd65535);
    hold_req = 1;
    random_phase(30);

    drain();
    cfg_write(CFG_ICOUNT, 16'd31);
    cfg_write(CFG_NCOUNT, 16'd0);
    random_phase(30);

    while (random_sent < RANDOM_ITEMS) begin
      drain();
      cfg_write(CFG_ICOUNT, 16'($urandom_range(1, 6)));
      cfg_write(CFG_NCOUNT, 16'($urandom_range(1, 6)));
      cfg_write(CFG_RATE, 16'($urandom));
      random_phase(30);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
